// ===== hw/rtl/tdut_pkg.sv =====
`default_nettype none

package tdut_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RX_FIRST_WAIT = 2'd0,
    CFG_RX_BIT_PERIOD = 2'd1,
    CFG_TX_BIT_PERIOD = 2'd2
  } cfg_idx_t;

  localparam logic [7:0] RxFirstWaitRst = 8'd4;
  localparam logic [7:0] RxBitPeriodRst = 8'd3;
  localparam logic [7:0] TxBitPeriodRst = 8'd3;

  // 8 data bits + stop position, for rx and tx alike
  localparam logic [3:0] RxBitCount = 4'd9;
  localparam logic [3:0] TxBitCount = 4'd9;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       pending;
  } rx_stat_t;

  typedef struct packed {
    logic pin;
    logic accepted;
    logic idle;
  } tx_stat_t;

  typedef struct packed {
    logic       tx_line;
    logic       send_accepted;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       tx_idle;
    logic       rx_pending;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tdut_rx.sv =====
`default_nettype none

module tdut_rx
  import tdut_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic       rx_line,
  input  wire logic       take_request,
  input  wire logic [7:0] first_wait,
  input  wire logic [7:0] bit_period,
  output rx_stat_t        stat
);

  logic       active_r, active_nxt;
  logic       complete_r, complete_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] hold_r, hold_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [3:0] bits_r, bits_nxt;

  logic       take_hit;
  logic [7:0] cnt_dec;
  logic [3:0] bits_dec;

  assign take_hit = take_request && complete_r;
  assign cnt_dec  = cnt_r - 8'd1;
  assign bits_dec = bits_r - 4'd1;

  always_comb begin
    active_nxt   = active_r;
    complete_nxt = complete_r && !take_hit;
    shift_nxt    = shift_r;
    hold_nxt     = hold_r;
    cnt_nxt      = cnt_r;
    bits_nxt     = bits_r;
    if (active_r) begin
      cnt_nxt = cnt_dec;
      if (cnt_dec == 8'd0) begin
        cnt_nxt  = bit_period;
        bits_nxt = bits_dec;
        if (bits_dec == 4'd0) begin
          hold_nxt     = shift_r;
          active_nxt   = 1'b0;
          complete_nxt = 1'b1;
        end else begin
          shift_nxt = {rx_line, shift_r[7:1]};
        end
      end
    end else if (!rx_line) begin
      active_nxt = 1'b1;
      cnt_nxt    = first_wait;
      bits_nxt   = RxBitCount;
    end
  end

  assign stat.valid   = take_hit;
  assign stat.data    = take_hit ? hold_r : 8'd0;
  assign stat.pending = complete_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      complete_r <= 1'b0;
      shift_r    <= 8'd0;
      hold_r     <= 8'd0;
      cnt_r      <= 8'd0;
      bits_r     <= 4'd0;
    end else if (step) begin
      active_r   <= active_nxt;
      complete_r <= complete_nxt;
      shift_r    <= shift_nxt;
      hold_r     <= hold_nxt;
      cnt_r      <= cnt_nxt;
      bits_r     <= bits_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tdut_tx.sv =====
`default_nettype none

module tdut_tx
  import tdut_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic       send_request,
  input  wire logic [7:0] send_byte,
  input  wire logic [7:0] bit_period,
  output tx_stat_t        stat
);

  logic       active_r, active_nxt;
  logic       complete_r, complete_nxt;
  logic       pin_r, pin_nxt;
  logic [7:0] hold_r, hold_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [3:0] bits_r, bits_nxt;

  logic       send_hit;
  logic       active_mid;
  logic [7:0] cnt_dec;
  logic [3:0] bits_dec;

  assign send_hit   = send_request && complete_r;
  assign active_mid = active_r || send_hit;
  assign cnt_dec    = cnt_r - 8'd1;
  assign bits_dec   = bits_r - 4'd1;

  always_comb begin
    active_nxt   = active_mid;
    complete_nxt = complete_r && !send_hit;
    pin_nxt      = pin_r;
    hold_nxt     = send_hit ? send_byte : hold_r;
    shift_nxt    = shift_r;
    cnt_nxt      = cnt_dec;
    bits_nxt     = bits_r;
    if (cnt_dec == 8'd0) begin
      cnt_nxt = bit_period;
      if (active_mid) begin
        if (bits_r == 4'd0) begin
          pin_nxt   = 1'b0;
          shift_nxt = hold_nxt;
          bits_nxt  = TxBitCount;
        end else begin
          shift_nxt = {1'b0, shift_r[7:1]};
          bits_nxt  = bits_dec;
          if (bits_dec == 4'd0) begin
            pin_nxt      = 1'b1;
            active_nxt   = 1'b0;
            complete_nxt = 1'b1;
          end else begin
            pin_nxt = shift_r[0];
          end
        end
      end
    end
  end

  assign stat.pin      = pin_nxt;
  assign stat.accepted = send_hit;
  assign stat.idle     = complete_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      complete_r <= 1'b1;
      pin_r      <= 1'b1;
      hold_r     <= 8'd0;
      shift_r    <= 8'd0;
      cnt_r      <= 8'd0;
      bits_r     <= 4'd0;
    end else if (step) begin
      active_r   <= active_nxt;
      complete_r <= complete_nxt;
      pin_r      <= pin_nxt;
      hold_r     <= hold_nxt;
      shift_r    <= shift_nxt;
      cnt_r      <= cnt_nxt;
      bits_r     <= bits_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tdut_obuf.sv =====
`default_nettype none

module tdut_obuf
  import tdut_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire res_t push_data,
  output logic      full,
  output logic      out_valid,
  input  wire logic out_stall,
  output res_t      out_data
);

  logic main_v_r, skid_v_r;
  res_t main_r, skid_r;
  logic pop;

  assign pop       = main_v_r && !out_stall;
  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (main_v_r && !pop) begin
        skid_v_r <= 1'b1;
      end else begin
        main_v_r <= 1'b1;
      end
    end else if (pop) begin
      main_v_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) begin
        main_r <= skid_r;
      end
    end else if (push) begin
      if (main_v_r && !pop) begin
        skid_r <= push_data;
      end else begin
        main_r <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tick_driven_uart_transceiver_unit.sv =====
`default_nettype none

// Tick-driven 8N1 UART transceiver. Each input word is one baud tick: the
// receive pin level plus host requests to send a byte or take the received
// byte; each tick yields exactly one result word with the transmit pin level,
// the send/take outcome and the idle/pending flags. Host requests are served
// before the receiver and transmitter advance, so a take in the tick that
// completes a byte leaves that byte pending. The stop bit is not checked.
// The transmit divider starts at zero, so the first transmit period after
// reset is 256 ticks; a period or wait register of zero also gives 256 ticks.
// Throughput is one tick per clock while the buffer is not full: the tick
// update is combinational logic into the state registers, and a two-entry
// output buffer keeps input flowing while one result waits. Write the
// configuration registers only while no result is outstanding.

module tick_driven_uart_transceiver_unit
  import tdut_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_rx_line,
  input  wire logic                in_send_request,
  input  wire logic [7:0]          in_send_byte,
  input  wire logic                in_take_request,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     out_tx_line,
  output logic                     out_send_accepted,
  output logic                     out_rx_valid,
  output logic [7:0]               out_rx_data,
  output logic                     out_tx_idle,
  output logic                     out_rx_pending
);

  logic [7:0] rx_first_wait_r, rx_bit_period_r, tx_bit_period_r;
  logic       step;
  logic       full;
  rx_stat_t   rx_stat;
  tx_stat_t   tx_stat;
  res_t       res, out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_first_wait_r <= RxFirstWaitRst;
      rx_bit_period_r <= RxBitPeriodRst;
      tx_bit_period_r <= TxBitPeriodRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RX_FIRST_WAIT: rx_first_wait_r <= cfg_data;
        CFG_RX_BIT_PERIOD: rx_bit_period_r <= cfg_data;
        CFG_TX_BIT_PERIOD: tx_bit_period_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = full;
  assign step     = in_valid && !full;

  tdut_rx u_rx (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .rx_line      (in_rx_line),
    .take_request (in_take_request),
    .first_wait   (rx_first_wait_r),
    .bit_period   (rx_bit_period_r),
    .stat         (rx_stat)
  );

  tdut_tx u_tx (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .send_request (in_send_request),
    .send_byte    (in_send_byte),
    .bit_period   (tx_bit_period_r),
    .stat         (tx_stat)
  );

  always_comb begin
    res.tx_line       = tx_stat.pin;
    res.send_accepted = tx_stat.accepted;
    res.rx_valid      = rx_stat.valid;
    res.rx_data       = rx_stat.data;
    res.tx_idle       = tx_stat.idle;
    res.rx_pending    = rx_stat.pending;
  end

  tdut_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign out_tx_line       = out_res.tx_line;
  assign out_send_accepted = out_res.send_accepted;
  assign out_rx_valid      = out_res.rx_valid;
  assign out_rx_data       = out_res.rx_data;
  assign out_tx_idle       = out_res.tx_idle;
  assign out_rx_pending    = out_res.rx_pending;

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
module tb;
  import tdut_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_rx_line = 1'b1;
  logic in_send_request = 1'b0;
  logic [7:0] in_send_byte = '0;
  logic in_take_request = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_tx_line;
  logic out_send_accepted;
  logic out_rx_valid;
  logic [7:0] out_rx_data;
  logic out_tx_idle;
  logic out_rx_pending;

  tick_driven_uart_transceiver_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_rx_line(in_rx_line),
    .in_send_request(in_send_request),
    .in_send_byte(in_send_byte),
    .in_take_request(in_take_request),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_tx_line(out_tx_line),
    .out_send_accepted(out_send_accepted),
    .out_rx_valid(out_rx_valid),
    .out_rx_data(out_rx_data),
    .out_tx_idle(out_tx_idle),
    .out_rx_pending(out_rx_pending)
  );

  always #5 clk = ~clk;

  // transceiver state as seen by the bench
  logic [7:0] first_wait = RxFirstWaitRst;
  logic [7:0] rx_period = RxBitPeriodRst;
  logic [7:0] tx_period = TxBitPeriodRst;
  logic tx_busy = 1'b0;
  logic tx_done = 1'b1;
  logic rx_busy = 1'b0;
  logic rx_ready = 1'b0;
  logic tx_level = 1'b1;
  logic [7:0] tx_buf = '0;
  logic [7:0] tx_sr = '0;
  logic [7:0] rx_sr = '0;
  logic [7:0] rx_buf = '0;
  logic [7:0] tx_div = '0;
  logic [7:0] rx_div = '0;
  logic [3:0] tx_cnt = '0;
  logic [3:0] rx_cnt = '0;

  res_t due_results[$];
  logic rx_wave[$];
  int mismatches = 0;
  int unsigned cycles = 0;
  bit steady = 1'b0;

  function automatic res_t advance_uart(input logic line, input logic send,
                                        input logic [7:0] sbyte, input logic take);
    res_t r;
    logic bit_out;
    r = '0;
    if (send && tx_done) begin
      tx_buf = sbyte;
      tx_done = 1'b0;
      tx_busy = 1'b1;
      r.send_accepted = 1'b1;
    end
    if (take && rx_ready) begin
      r.rx_data = rx_buf;
      r.rx_valid = 1'b1;
      rx_ready = 1'b0;
    end
    if (rx_busy) begin
      rx_div = rx_div - 8'd1;
      if (rx_div == 8'd0) begin
        rx_div = rx_period;
        rx_cnt = rx_cnt - 4'd1;
        if (rx_cnt == 4'd0) begin
          rx_buf = rx_sr;
          rx_busy = 1'b0;
          rx_ready = 1'b1;
        end else begin
          rx_sr = {line, rx_sr[7:1]};
        end
      end
    end else if (!line) begin
      rx_busy = 1'b1;
      rx_div = first_wait;
      rx_cnt = RxBitCount;
    end
    tx_div = tx_div - 8'd1;
    if (tx_div == 8'd0) begin
      tx_div = tx_period;
      if (tx_busy) begin
        if (tx_cnt == 4'd0) begin
          tx_level = 1'b0;
          tx_sr = tx_buf;
          tx_cnt = TxBitCount;
        end else begin
          bit_out = tx_sr[0];
          tx_sr = tx_sr >> 1;
          tx_cnt = tx_cnt - 4'd1;
          if (tx_cnt == 4'd0) begin
            tx_level = 1'b1;
            tx_busy = 1'b0;
            tx_done = 1'b1;
          end else begin
            tx_level = bit_out;
          end
        end
      end
    end
    r.tx_line = tx_level;
    r.tx_idle = tx_done;
    r.rx_pending = rx_ready;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t %s: expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        mismatches++;
        $display("%0t unexpected word: expected none, actual %h", $time,
                 {out_tx_line, out_send_accepted, out_rx_valid, out_rx_data,
                  out_tx_idle, out_rx_pending});
      end else begin
        want = due_results.pop_front();
        check_field("tx_line", 8'(want.tx_line), 8'(out_tx_line));
        check_field("send_accepted", 8'(want.send_accepted), 8'(out_send_accepted));
        check_field("rx_valid", 8'(want.rx_valid), 8'(out_rx_valid));
        check_field("rx_data", want.rx_data, out_rx_data);
        check_field("tx_idle", 8'(want.tx_idle), 8'(out_tx_idle));
        check_field("rx_pending", 8'(want.rx_pending), 8'(out_rx_pending));
      end
    end
    out_stall <= !steady && ($urandom_range(99) < 27);
  end

  task automatic send_tick(input logic line, input logic send,
                           input logic [7:0] sbyte, input logic take);
    while (!steady && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_line <= line;
    in_send_request <= send;
    in_send_byte <= sbyte;
    in_take_request <= take;
    do @(posedge clk); while (in_stall);
    due_results.push_back(advance_uart(line, send, sbyte, take));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_RX_FIRST_WAIT: first_wait = val;
      CFG_RX_BIT_PERIOD: rx_period = val;
      CFG_TX_BIT_PERIOD: tx_period = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] fw, input logic [7:0] rp,
                            input logic [7:0] tp, input bit with_unused);
    settle();
    if (with_unused) cfg_put(CfgIdxUnused, 8'd0);
    cfg_put(CFG_RX_FIRST_WAIT, fw);
    cfg_put(CFG_RX_BIT_PERIOD, rp);
    cfg_put(CFG_TX_BIT_PERIOD, tp);
    cfg_we <= 1'b0;
  endtask

  // well-formed frames with random data, some truncated, some line noise
  function automatic void plan_rx_wave(input int bit_len);
    logic [9:0] frame;
    int stop_at;
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(1, 8)) rx_wave.push_back(1'($urandom));
    end else begin
      frame = {1'b1, 8'($urandom), 1'b0};
      stop_at = ($urandom_range(99) < 10) ? $urandom_range(1, 9) : 10;
      repeat ($urandom_range(0, 4)) rx_wave.push_back(1'b1);
      for (int i = 0; i < stop_at; i++) repeat (bit_len) rx_wave.push_back(frame[i]);
    end
  endfunction

  task automatic run_traffic(input int count, input logic [7:0] fw,
                             input logic [7:0] rp, input logic [7:0] tp);
    int bit_len;
    set_config(fw, rp, tp, 1'b0);
    bit_len = (rp >= 1 && rp <= 16) ? int'(rp) : $urandom_range(1, 4);
    rx_wave.delete();
    repeat (count) begin
      if (rx_wave.size() == 0) plan_rx_wave(bit_len);
      send_tick(rx_wave.pop_front(), $urandom_range(99) < 25, 8'($urandom),
                $urandom_range(99) < 30);
    end
  endtask

  task automatic test_host_requests();
    send_tick(1'b1, 1'b0, 8'h00, 1'b1);  // take, nothing waiting
    send_tick(1'b1, 1'b1, 8'h00, 1'b0);
    send_tick(1'b1, 1'b1, 8'hFF, 1'b1);  // send while busy
    send_tick(1'b1, 1'b0, 8'h00, 1'b0);
  endtask

  task automatic test_fast_frame();
    logic [9:0] frame;
    set_config(8'd1, 8'd1, 8'd1, 1'b1);
    frame = {1'b1, 8'hA5, 1'b0};
    // take lands on the latch tick, so the word stays pending
    for (int i = 0; i < 10; i++) send_tick(frame[i], i == 3, 8'hFF, i == 9);
    send_tick(1'b1, 1'b0, 8'h00, 1'b1);
  endtask

  task automatic test_min_periods();
    steady = 1'b1;
    run_traffic(250, 8'd1, 8'd1, 8'd1);
    steady = 1'b0;
  endtask

  task automatic test_default_periods();
    run_traffic(250, RxFirstWaitRst, RxBitPeriodRst, TxBitPeriodRst);
  endtask

  task automatic test_max_periods();
    run_traffic(250, 8'd255, 8'd1, 8'd255);
  endtask

  task automatic test_zero_periods();
    run_traffic(150, 8'd0, 8'd2, 8'd0);
  endtask

  task automatic test_mixed_periods();
    repeat (3) run_traffic(100, 8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)),
                           8'($urandom_range(1, 8)));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_host_requests();
    test_fast_frame();
    test_min_periods();
    test_default_periods();
    test_max_periods();
    test_zero_periods();
    test_mixed_periods();
    settle();
    repeat (5) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== tick_driven_uart_transceiver_unit.f =====
hw/rtl/tdut_pkg.sv
hw/rtl/tdut_rx.sv
hw/rtl/tdut_tx.sv
hw/rtl/tdut_obuf.sv
hw/rtl/tick_driven_uart_transceiver_unit.sv
bench/tb.sv
